### hdl/rcc_pkg.sv
// shared types, constants and codes of the grid raycast column unit
package rcc_pkg;

   localparam int MAP_SIDE        = 16;
   localparam int MAP_BITS        = $clog2(MAP_SIDE);
   localparam int CELL_COUNT      = MAP_SIDE * MAP_SIDE;
   localparam int CELL_BITS       = $clog2(CELL_COUNT);
   localparam int TRIG_TABLE_SIZE = 1024;
   localparam int TRIG_BITS       = $clog2(TRIG_TABLE_SIZE);
   localparam logic [15:0] ANGLE_MASK = 16'(((1 << TRIG_BITS) - 1) << (16 - TRIG_BITS));

   localparam logic [14:0] POLY_A = 15'd25736;
   localparam logic [14:0] POLY_B = 15'd10512;
   localparam logic [14:0] POLY_C = 15'd1160;
   localparam logic [14:0] QUARTER = 15'd16384;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_BITS  = $clog2(QUEUE_DEPTH);

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [2:0] {
      CSR_FOV    = 3'd0,
      CSR_DEPTH  = 3'd1,
      CSR_STEP   = 3'd2,
      CSR_WIDTH  = 3'd3,
      CSR_HEIGHT = 3'd4
   } csr_index_type;

   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_CAST  = 1'b1
   } action_type;

   // sanitized configuration, zero and oversize values of depth, step and screen sizes already folded
   typedef struct packed {
      logic [15:0] fov;
      logic [15:0] depth;
      logic [11:0] step;
      logic [10:0] width;
      logic [10:0] height;
   } cfg_type;

   typedef struct packed {
      logic               is_cast;
      logic [7:0]         cell_idx;
      logic               cell_wall;
      logic [15:0]        px;
      logic [15:0]        py;
      logic signed [15:0] cs;
      logic signed [15:0] sn;
      logic [9:0]         col;
   } item_type;

   typedef struct packed {
      logic [9:0]  col;
      logic [15:0] distance;
      logic        left;
      logic [9:0]  first;
      logic [9:0]  last;
      logic [7:0]  shade;
   } result_type;

   typedef enum logic [1:0] {
      FR_IDLE, FR_DIV, FR_ANGLE, FR_TRIG
   } front_state_type;

   typedef enum logic [3:0] {
      BK_IDLE, BK_STEP, BK_PROD, BK_TEST, BK_LOOK,
      BK_ROWS, BK_QDIV, BK_EDGE, BK_SDIV, BK_OUT
   } back_state_type;

endpackage

### hdl/rcc_queue.sv
// two-entry item queue between the front and back parts
module rcc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rcc_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output rcc_pkg::item_type pop_item,
   output logic              empty
);
   import rcc_pkg::*;

   item_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_BITS:0]   count_ff, count_in;

   assign full     = (count_ff == (QUEUE_BITS+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end
endmodule

### hdl/rcc_front.sv
// front part: accepts items, derives ray angle and its sine and cosine
module rcc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  rcc_pkg::cfg_type             cfg,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [rcc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                         req_tuser,
   output logic                         push,
   output rcc_pkg::item_type            push_item,
   input  logic                         full
);
   import rcc_pkg::*;

   front_state_type    state_ff, state_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [25:0]        num_ff, num_in;
   logic [10:0]        rem_ff, rem_in;
   logic [15:0]        qa_ff, qa_in;
   logic [1:0]         phase_ff, phase_in;
   logic               second_ff, second_in;
   logic [14:0]        z2_ff, z2_in, t_ff, t_in;
   logic signed [15:0] sn_ff, sn_in, cs_ff, cs_in;
   logic [15:0]        px_ff, py_ff, view_ff;
   logic [9:0]         col_ff;
   logic               take;

   logic [11:0] trial;
   logic [15:0] ang;
   logic [1:0]  quad;
   logic [14:0] z, mul_a, mul_b;
   logic [29:0] prod;
   logic [14:0] prod_s;

   assign trial  = {rem_ff, num_ff[25]};
   assign ang    = view_ff - {1'b0, cfg.fov[15:1]} + num_ff[15:0];
   assign quad   = qa_ff[15:14] + {1'b0, second_ff};
   assign z      = quad[0] ? (QUARTER - {1'b0, qa_ff[13:0]}) : {1'b0, qa_ff[13:0]};
   assign prod   = mul_a * mul_b;
   assign prod_s = prod[28:14];

   always_comb begin
      unique case (phase_ff)
         2'd0:    begin mul_a = z;     mul_b = z;      end
         2'd1:    begin mul_a = z2_ff; mul_b = POLY_C; end
         2'd2:    begin mul_a = z2_ff; mul_b = t_ff;   end
         default: begin mul_a = z;     mul_b = t_ff;   end
      endcase
   end

   assign req_tready = (state_ff == FR_IDLE) && !full;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      qa_in     = qa_ff;
      phase_in  = phase_ff;
      second_in = second_ff;
      z2_in     = z2_ff;
      t_in      = t_ff;
      sn_in     = sn_ff;
      cs_in     = cs_ff;
      push      = 1'b0;
      push_item = '0;
      push_item.is_cast   = (req_tuser == ACT_CAST);
      push_item.cell_idx  = req_tdata[7:0];
      push_item.cell_wall = req_tdata[8];
      unique case (state_ff)
         FR_IDLE: begin
            if (take) begin
               if (req_tuser == ACT_WRITE) begin
                  push = 1'b1;
               end else begin
                  num_in   = 26'(req_tdata[66:57] * cfg.fov);
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = FR_DIV;
               end
            end
         end
         FR_DIV: begin
            // restoring division of column times fov by screen width
            if (trial >= {1'b0, cfg.width}) begin
               rem_in = 11'(trial - {1'b0, cfg.width});
               num_in = {num_ff[24:0], 1'b1};
            end else begin
               rem_in = trial[10:0];
               num_in = {num_ff[24:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd25) begin
               state_in = FR_ANGLE;
            end
         end
         FR_ANGLE: begin
            qa_in     = ang & ANGLE_MASK;
            phase_in  = '0;
            second_in = 1'b0;
            state_in  = FR_TRIG;
         end
         FR_TRIG: begin
            // quarter-wave polynomial, one product per cycle, sine then cosine; the last product waits for queue space
            unique case (phase_ff)
               2'd0:    z2_in = prod_s;
               2'd1:    t_in  = POLY_B - prod_s;
               2'd2:    t_in  = POLY_A - prod_s;
               default: begin
                  if (second_ff) begin
                     cs_in = quad[1] ? -$signed({1'b0, prod_s}) : $signed({1'b0, prod_s});
                  end else begin
                     sn_in = quad[1] ? -$signed({1'b0, prod_s}) : $signed({1'b0, prod_s});
                  end
               end
            endcase
            phase_in = phase_ff + 1'b1;
            if (phase_ff == 2'd3) begin
               second_in = 1'b1;
               if (second_ff) begin
                  // wait here for queue space
                  phase_in  = phase_ff;
                  second_in = second_ff;
                  cs_in     = cs_ff;
                  if (!full) begin
                     push     = 1'b1;
                     state_in = FR_IDLE;
                  end
               end
            end
            push_item.is_cast   = 1'b1;
            push_item.cell_idx  = '0;
            push_item.cell_wall = 1'b0;
            push_item.px        = px_ff;
            push_item.py        = py_ff;
            push_item.sn        = sn_ff;
            push_item.cs        = quad[1] ? -$signed({1'b0, prod_s}) : $signed({1'b0, prod_s});
            push_item.col       = col_ff;
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      qa_ff     <= qa_in;
      phase_ff  <= phase_in;
      second_ff <= second_in;
      z2_ff     <= z2_in;
      t_ff      <= t_in;
      sn_ff     <= sn_in;
      cs_ff     <= cs_in;
      if (take) begin
         px_ff   <= req_tdata[24:9];
         py_ff   <= req_tdata[40:25];
         view_ff <= req_tdata[56:41];
         col_ff  <= req_tdata[66:57];
      end
   end
endmodule

### hdl/rcc_back.sv
// back part: map store, ray march, row and shade divisions, result register
module rcc_back (
   input  logic                           clock,
   input  logic                           reset,
   input  rcc_pkg::cfg_type               cfg,
   input  logic                           empty,
   input  rcc_pkg::item_type              pop_item,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rcc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import rcc_pkg::*;

   back_state_type     state_ff, state_in;
   item_type           item_ff;
   logic [16:0]        d_ff, d_in;
   logic               left_ff, left_in;
   logic signed [33:0] prodx_ff, prody_ff;
   logic [5:0]         cnt_ff, cnt_in;
   logic [34:0]        num_ff, num_in;
   logic [16:0]        rem_ff, rem_in, den_ff, den_in;
   logic [9:0]         first_ff, first_in, last_ff, last_in;
   logic               map_ff [CELL_COUNT];
   logic               rd_ff;
   logic               rd_en;
   logic [CELL_BITS-1:0] rd_addr;
   logic               wr_en;
   result_type         rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic signed [34:0] posx, posy;
   logic               inx, iny;
   logic [MAP_BITS-1:0] cx, cy;
   logic [17:0]        trial;
   logic signed [36:0] ceil12, floor12m1;
   logic [23:0]        shade_num;
   logic [16:0]        depth17;

   assign depth17 = {1'b0, cfg.depth};
   assign posx = $signed({5'b0, item_ff.px, 14'b0}) + {prodx_ff[33], prodx_ff};
   assign posy = $signed({5'b0, item_ff.py, 14'b0}) + {prody_ff[33], prody_ff};
   // truncation toward zero keeps small negatives in cell zero
   assign inx = (!posx[34] && (posx[34:26] < 9'(MAP_SIDE))) || (&posx[34:26] && |posx[25:0]);
   assign iny = (!posy[34] && (posy[34:26] < 9'(MAP_SIDE))) || (&posy[34:26] && |posy[25:0]);
   assign cx  = posx[34] ? '0 : posx[26 +: MAP_BITS];
   assign cy  = posy[34] ? '0 : posy[26 +: MAP_BITS];
   assign rd_addr = CELL_BITS'(cy * MAP_SIDE + cx);
   assign trial = {rem_ff, num_ff[34]};
   assign ceil12    = $signed({15'b0, cfg.height, 11'b0}) - $signed({2'b0, num_ff});
   assign floor12m1 = $signed({15'b0, cfg.height, 11'b0}) + $signed({2'b0, num_ff}) - 37'sd1;
   assign shade_num = 24'((cfg.depth - d_ff[15:0]) * 8'd255);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.shade, rsp_ff.last, rsp_ff.first, rsp_ff.left,
                        rsp_ff.distance, rsp_ff.col};

   always_comb begin
      state_in     = state_ff;
      d_in         = d_ff;
      left_in      = left_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pop          = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               if (pop_item.is_cast) begin
                  d_in     = '0;
                  left_in  = 1'b0;
                  state_in = BK_STEP;
               end else begin
                  wr_en = ({1'b0, pop_item.cell_idx} < 9'(CELL_COUNT));
               end
            end
         end
         BK_STEP: begin
            d_in     = d_ff + {5'b0, cfg.step};
            state_in = BK_PROD;
         end
         BK_PROD: state_in = BK_TEST;
         BK_TEST: begin
            if (!inx || !iny) begin
               left_in  = 1'b1;
               d_in     = depth17;
               state_in = BK_ROWS;
            end else begin
               rd_en    = 1'b1;
               state_in = BK_LOOK;
            end
         end
         BK_LOOK: begin
            if (rd_ff || (d_ff >= depth17)) begin
               state_in = BK_ROWS;
            end else begin
               state_in = BK_STEP;
            end
         end
         BK_ROWS: begin
            num_in   = {cfg.height, 24'b0};
            den_in   = d_ff;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = BK_QDIV;
         end
         BK_QDIV, BK_SDIV: begin
            // restoring division, one quotient bit per cycle
            if (trial >= {1'b0, den_ff}) begin
               rem_in = 17'(trial - {1'b0, den_ff});
               num_in = {num_ff[33:0], 1'b1};
            end else begin
               rem_in = trial[16:0];
               num_in = {num_ff[33:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd34) begin
               state_in = (state_ff == BK_QDIV) ? BK_EDGE : BK_OUT;
            end
         end
         BK_EDGE: begin
            first_in = ceil12[36] ? '0 : 10'(ceil12[21:12] + 10'd1);
            if ((floor12m1 >>> 12) > $signed({26'b0, cfg.height} - 37'sd1)) begin
               last_in = 10'(cfg.height - 11'd1);
            end else begin
               last_in = floor12m1[21:12];
            end
            if (d_ff >= depth17) begin
               num_in   = '0;
               state_in = BK_OUT;
            end else begin
               num_in   = {11'b0, shade_num};
               den_in   = depth17;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = BK_SDIV;
            end
         end
         BK_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in.col      = item_ff.col;
               rsp_in.distance = d_ff[16] ? 16'hFFFF : d_ff[15:0];
               rsp_in.left     = left_ff;
               rsp_in.first    = first_ff;
               rsp_in.last     = last_ff;
               rsp_in.shade    = num_ff[7:0];
               rsp_valid_in    = 1'b1;
               state_in        = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= pop_item;
      end
      d_ff     <= d_in;
      left_ff  <= left_in;
      prodx_ff <= $signed({1'b0, d_ff}) * item_ff.cs;
      prody_ff <= $signed({1'b0, d_ff}) * item_ff.sn;
      cnt_ff   <= cnt_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      rsp_ff   <= rsp_in;
   end

   // map store, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_ff[pop_item.cell_idx[CELL_BITS-1:0]] <= pop_item.cell_wall;
      end
      if (rd_en) begin
         rd_ff <= map_ff[rd_addr];
      end
   end
endmodule

### hdl/grid_raycast_column_unit.sv
// top level of the grid raycast column unit
// a map write passes through the front and the back and gives no result
// a cast runs the column divider, angle and trig in the front,
// then the march steps in the back, followed by the row and shade dividers
// the march loop runs step, multiply, bound test and map read in turn
// reset is synchronous active high, map cells are undefined until written
module grid_raycast_column_unit (
   input  logic        clock,
   input  logic        reset,
   // fields low to high: cell_index, cell_is_wall, player_x, player_y,
   // view_angle, column, zero fill
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,
   // fields: action
   input  logic        req_tuser,
   // fields low to high: out_column, wall_distance, left_map, first_wall_row,
   // last_wall_row, wall_shade, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import rcc_pkg::*;

   // raw register values as written
   logic [15:0] fov_ff, depth_ff;
   logic [11:0] step_ff;
   logic [10:0] width_ff, height_ff;
   cfg_type     cfg;
   logic        push, pop, full, empty;
   item_type    push_item, pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         fov_ff    <= 16'd8192;
         depth_ff  <= 16'd32768;
         step_ff   <= 12'd205;
         width_ff  <= 11'd640;
         height_ff <= 11'd480;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_FOV:    fov_ff    <= csr_wdata;
            CSR_DEPTH:  depth_ff  <= csr_wdata;
            CSR_STEP:   step_ff   <= csr_wdata[11:0];
            CSR_WIDTH:  width_ff  <= csr_wdata[10:0];
            CSR_HEIGHT: height_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // zero depth, step and screen sizes act as one, screen sizes cap at 1024
   always_comb begin
      cfg.fov    = fov_ff;
      cfg.depth  = (depth_ff == '0) ? 16'd1 : depth_ff;
      cfg.step   = (step_ff == '0) ? 12'd1 : step_ff;
      cfg.width  = (width_ff == '0) ? 11'd1 : (width_ff > 11'd1024) ? 11'd1024 : width_ff;
      cfg.height = (height_ff == '0) ? 11'd1 :
                   (height_ff > 11'd1024) ? 11'd1024 : height_ff;
   end

   // front classifies and prepares the ray direction
   rcc_front u_front (
      .clock, .reset, .cfg,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .push, .push_item, .full
   );

   // short queue lets each side stall on its own
   rcc_queue u_queue (
      .clock, .reset, .push, .push_item, .full, .pop, .pop_item, .empty
   );

   // back marches the ray and holds the result until transfer
   rcc_back u_back (
      .clock, .reset, .cfg, .empty, .pop_item, .pop,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );
endmodule

### hdl/rcc_checker.sv
// port-level checks of the grid raycast column unit
module rcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
   a_left_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[26] |-> rsp_tdata[54:47] == 8'd0)
      else $error("ray left map but shade nonzero");
   a_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[25:10] != 16'd0)
      else $error("zero wall distance");
endmodule

bind grid_raycast_column_unit rcc_checker u_checker (.*);
